>>> sv/fde_pkg.sv
// Shared types and constants for the feedback delay echo.
package fde_pkg;

  localparam int GAIN_W   = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int MODE_W   = 2;

  // Largest Q0.16 feedback code below 0.99; above it the gain is used as zero.
  localparam logic [GAIN_W-1:0] FEEDBACK_LIMIT = 16'd64880;

  typedef enum logic [MODE_W-1:0] {
    MODE_PROC_ADV = 2'd0,
    MODE_PROC     = 2'd1,
    MODE_ADV      = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY_LENGTH  = 2'd0,
    REG_FEEDBACK_GAIN = 2'd1,
    REG_WET_GAIN      = 2'd2,
    REG_DRY_GAIN      = 2'd3
  } reg_idx_t;

endpackage

>>> sv/feedback_delay_echo.sv
// Feedback delay echo: circular delay store with feedback and wet/dry mix.
//
// Accepts one sample beat per cycle while in_ready is high and returns one
// result beat for each, through stage B, stage C and the output register.
// The pipeline is: input beat -> B (store read data registered, delayed
// sample resolved, store written, feedback applied) -> C (wet/dry mix) ->
// output register. Each stage holds when the stage after it is full, so
// stalls on the output side back up into in_ready without losing or
// repeating beats. The store is a single memory with one write and one
// registered read per cycle; a read that hits the location written by the
// previous beat is forwarded, and a zero delay reads back the sample written
// by the same beat. After reset the block runs a clearing pass that zeroes
// the store, during which in_ready is low. Writing delay_length holds
// in_ready low while the distance modulo STORE_DEPTH is recomputed by a
// small reciprocal-multiply pipeline. Configuration is taken at any time
// through cfg_we / cfg_addr / cfg_wdata but must only change while no beat
// is in flight. Feedback gains above 64880 are used as zero.
module feedback_delay_echo #(
  parameter int STORE_DEPTH = 65536,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  input  logic [fde_pkg::MODE_W-1:0]    in_mode,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_sample_out,
  input  logic                          cfg_we,
  input  logic [fde_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [fde_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int SB     = SAMPLE_BITS;
  localparam int GW     = fde_pkg::GAIN_W;
  localparam int ACC_W  = SB + GW + 2;
  // Ceiling reciprocal for the 16-bit modulo; exact for every 16-bit value.
  localparam longint unsigned RECIP = ((64'd1 << 32) + STORE_DEPTH - 1) / STORE_DEPTH;
  localparam int P_W    = fde_pkg::CFG_W + 33;
  localparam int QD_W   = fde_pkg::CFG_W + ADDR_W + 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);

  // Saturate floor(v / 2^16) to the signed sample range.
  function automatic logic signed [SB-1:0] sat_shift(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] sh;
    logic                    fits;
    sh   = v >>> GW;
    fits = (&sh[ACC_W-1:SB-1]) | ~(|sh[ACC_W-1:SB-1]);
    if (fits)
      sat_shift = sh[SB-1:0];
    else if (sh[ACC_W-1])
      sat_shift = {1'b1, {(SB-1){1'b0}}};
    else
      sat_shift = {1'b0, {(SB-1){1'b1}}};
  endfunction

  // ---------------- configuration ----------------
  logic [GW-1:0]          dl_r, fb_r, wet_r, dry_r;
  logic [GW-1:0]          dl_d1_r, dl_d2_r;
  logic [P_W-1:0]         p_r;
  logic [QD_W-1:0]        qd_r;
  logic [ADDR_W-1:0]      dist_r;
  logic [1:0]             busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dl_r   <= GW'(1);
      fb_r   <= '0;
      wet_r  <= '1;
      dry_r  <= '1;
      busy_r <= 2'd3;
    end else begin
      if (cfg_we) begin
        unique case (fde_pkg::reg_idx_t'(cfg_addr))
          fde_pkg::REG_DELAY_LENGTH:  dl_r  <= cfg_wdata;
          fde_pkg::REG_FEEDBACK_GAIN: fb_r  <= cfg_wdata;
          fde_pkg::REG_WET_GAIN:      wet_r <= cfg_wdata;
          fde_pkg::REG_DRY_GAIN:      dry_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cfg_we && fde_pkg::reg_idx_t'(cfg_addr) == fde_pkg::REG_DELAY_LENGTH)
        busy_r <= 2'd3;
      else if (busy_r != 2'd0)
        busy_r <= busy_r - 2'd1;
    end
  end

  // distance = delay_length mod STORE_DEPTH, free running, registered through p_r, qd_r and dist_r
  always_ff @(posedge clk) begin
    p_r     <= P_W'(dl_r) * P_W'(RECIP);
    dl_d1_r <= dl_r;
    qd_r    <= QD_W'(p_r[P_W-2:32]) * QD_W'(STORE_DEPTH);
    dl_d2_r <= dl_d1_r;
    dist_r  <= ADDR_W'(QD_W'(dl_d2_r) - qd_r);
  end

  // ---------------- clearing pass ----------------
  logic              clearing_r;
  logic [ADDR_W-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + ADDR_W'(1);
      if (clr_addr_r == LAST_ADDR)
        clearing_r <= 1'b0;
    end
  end

  // ---------------- handshake chain ----------------
  logic b_valid_r, c_valid_r, out_valid_r;
  logic out_free, c_fire, c_free, b_fire, b_free, in_fire;

  assign out_free = !out_valid_r || out_ready;
  assign c_fire   = c_valid_r && out_free;
  assign c_free   = !c_valid_r || c_fire;
  assign b_fire   = b_valid_r && c_free;
  assign b_free   = !b_valid_r || b_fire;
  assign in_ready = b_free && !clearing_r && (busy_r == 2'd0);
  assign in_fire  = in_valid && in_ready;

  // ---------------- write position and read address ----------------
  logic [ADDR_W-1:0]  wp_r;
  logic [ADDR_W-1:0]  rp_in;
  fde_pkg::mode_t     in_mode_e;
  logic               in_adv;

  assign in_mode_e = fde_pkg::mode_t'(in_mode);

  always_comb begin
    unique case (in_mode_e)
      fde_pkg::MODE_PROC_ADV: in_adv = 1'b1;
      fde_pkg::MODE_ADV:      in_adv = 1'b1;
      default:                in_adv = 1'b0;
    endcase
  end

  always_comb begin
    if (wp_r >= dist_r)
      rp_in = wp_r - dist_r;
    else
      rp_in = ADDR_W'((ADDR_W+1)'(wp_r) + (ADDR_W+1)'(STORE_DEPTH) - (ADDR_W+1)'(dist_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      wp_r <= '0;
    else if (in_fire && in_adv)
      wp_r <= (wp_r == LAST_ADDR) ? '0 : wp_r + ADDR_W'(1);
  end

  // ---------------- stage B: registered store read ----------------
  logic signed [SB-1:0] b_x_r;
  fde_pkg::mode_t       b_mode_r;
  logic [ADDR_W-1:0]    b_wp_r, b_rp_r;
  logic signed [SB-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n)
      b_valid_r <= 1'b0;
    else if (b_free)
      b_valid_r <= in_fire;
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      b_x_r    <= in_sample_in;
      b_mode_r <= in_mode_e;
      b_wp_r   <= wp_r;
      b_rp_r   <= rp_in;
    end
  end

  // store write: clearing pass, else a processing beat leaving stage B
  logic                 b_proc;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic signed [SB-1:0] mem_wdata;
  logic signed [SB-1:0] stored;

  assign mem_we    = clearing_r || (b_fire && b_proc);
  assign mem_waddr = clearing_r ? clr_addr_r : b_wp_r;
  assign mem_wdata = clearing_r ? '0 : stored;

  logic signed [SB-1:0] store_mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (mem_we)
      store_mem[mem_waddr] <= mem_wdata;
    if (in_fire)
      rdata_r <= store_mem[rp_in];
  end

  // ---------------- B compute: feedback, forward, resolve ----------------
  logic signed [SB-1:0] ld_r;
  logic                 fw_vld_r;
  logic [ADDR_W-1:0]    fw_addr_r;
  logic signed [SB-1:0] fw_data_r;
  logic [GW-1:0]        fb_eff;
  logic signed [ACC_W-1:0] fb_acc;
  logic signed [SB-1:0] b_d;

  always_comb begin
    unique case (b_mode_r)
      fde_pkg::MODE_PROC_ADV: b_proc = 1'b1;
      fde_pkg::MODE_PROC:     b_proc = 1'b1;
      default:                b_proc = 1'b0;
    endcase
  end

  assign fb_eff = (fb_r > fde_pkg::FEEDBACK_LIMIT) ? '0 : fb_r;
  assign fb_acc = (ACC_W'(b_x_r) <<< GW)
                + ACC_W'($signed(ld_r) * $signed({1'b0, fb_eff}));
  assign stored = sat_shift(fb_acc);

  // zero distance reads its own write; previous beat's write is forwarded
  always_comb begin
    if (b_rp_r == b_wp_r)
      b_d = stored;
    else if (fw_vld_r && fw_addr_r == b_rp_r)
      b_d = fw_data_r;
    else
      b_d = rdata_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld_r     <= '0;
      fw_vld_r <= 1'b0;
    end else if (b_fire && b_proc) begin
      ld_r     <= b_d;
      fw_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire && b_proc) begin
      fw_addr_r <= b_wp_r;
      fw_data_r <= stored;
    end
  end

  // ---------------- stage C: wet/dry mix ----------------
  logic signed [SB-1:0] c_d_r, c_x_r;
  logic                 c_mute_r;
  logic signed [ACC_W-1:0] mix_acc;

  always_ff @(posedge clk) begin
    if (!rst_n)
      c_valid_r <= 1'b0;
    else if (c_free)
      c_valid_r <= b_fire;
  end

  always_ff @(posedge clk) begin
    if (b_fire) begin
      c_d_r    <= b_d;
      c_x_r    <= b_x_r;
      c_mute_r <= !b_proc;
    end
  end

  assign mix_acc = ACC_W'($signed(c_d_r) * $signed({1'b0, wet_r}))
                 + ACC_W'($signed(c_x_r) * $signed({1'b0, dry_r}));

  // ---------------- output register ----------------
  logic signed [SB-1:0] out_sample_r;

  always_ff @(posedge clk) begin
    if (!rst_n)
      out_valid_r <= 1'b0;
    else if (out_free)
      out_valid_r <= c_fire;
  end

  always_ff @(posedge clk) begin
    if (c_fire)
      out_sample_r <= c_mute_r ? '0 : sat_shift(mix_acc);
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

endmodule

>>> verif/feedback_delay_echo_checker.sv
// Checker for the feedback delay echo: tracks the echo line, predicts each output beat, compares.
module feedback_delay_echo_checker #(
  parameter int STORE_DEPTH = 65536,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic signed [SAMPLE_BITS-1:0]  in_sample_in,
  input  logic [fde_pkg::MODE_W-1:0]     in_mode,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic signed [SAMPLE_BITS-1:0]  out_sample_out,
  input  logic                           cfg_we,
  input  logic [fde_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [fde_pkg::CFG_W-1:0]      cfg_wdata,
  output int                             mismatch_count,
  output int                             pending_count,
  output int                             checked_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow of the block's state and registers
  logic signed [SAMPLE_BITS-1:0] echo_line [STORE_DEPTH];
  int unsigned                   head;
  logic signed [SAMPLE_BITS-1:0] last_tap;
  logic [fde_pkg::CFG_W-1:0]     delay_len;
  logic [fde_pkg::CFG_W-1:0]     fb_gain;
  logic [fde_pkg::CFG_W-1:0]     wet;
  logic [fde_pkg::CFG_W-1:0]     dry;
  logic signed [SAMPLE_BITS-1:0] expected_mix [$];

  function automatic logic signed [SAMPLE_BITS-1:0] clamp_q(longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return SAMPLE_BITS'(hi);
    if (v < lo) return SAMPLE_BITS'(lo);
    return SAMPLE_BITS'(v);
  endfunction

  // one sample through the echo; >>> on signed longint floors toward minus infinity
  function automatic logic signed [SAMPLE_BITS-1:0] echo_step(
    logic signed [SAMPLE_BITS-1:0] x,
    logic [fde_pkg::MODE_W-1:0]    m
  );
    logic [fde_pkg::CFG_W-1:0]     fb;
    int unsigned                   wp;
    int unsigned                   rp;
    int unsigned                   tap_gap;
    logic signed [SAMPLE_BITS-1:0] mix;
    mix = '0;
    if (m == fde_pkg::MODE_PROC_ADV || m == fde_pkg::MODE_PROC) begin
      fb      = (fb_gain > fde_pkg::FEEDBACK_LIMIT) ? '0 : fb_gain;
      tap_gap = delay_len % STORE_DEPTH;
      wp      = head % STORE_DEPTH;
      rp      = (wp + STORE_DEPTH - tap_gap) % STORE_DEPTH;
      echo_line[wp] = clamp_q(((longint'(x) <<< 16) + longint'(last_tap) * longint'(fb)) >>> 16);
      last_tap = echo_line[rp];
      mix = clamp_q((longint'(last_tap) * longint'(wet) + longint'(x) * longint'(dry)) >>> 16);
    end
    if (m == fde_pkg::MODE_PROC_ADV || m == fde_pkg::MODE_ADV) head = (head + 1) % STORE_DEPTH;
    return mix;
  endfunction

  always @(posedge clk) begin
    logic signed [SAMPLE_BITS-1:0] want;
    if (!rst_n) begin
      for (int i = 0; i < STORE_DEPTH; i++) echo_line[i] = '0;
      head = 0;
      last_tap = '0;
      delay_len = 16'd1;
      fb_gain = '0;
      wet = '1;
      dry = '1;
      expected_mix.delete();
      mismatch_count = 0;
      checked_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          fde_pkg::REG_DELAY_LENGTH:  delay_len = cfg_wdata;
          fde_pkg::REG_FEEDBACK_GAIN: fb_gain = cfg_wdata;
          fde_pkg::REG_WET_GAIN:      wet = cfg_wdata;
          fde_pkg::REG_DRY_GAIN:      dry = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_mix.push_back(echo_step(in_sample_in, in_mode));
      if (out_valid && out_ready) begin
        if (expected_mix.size() == 0) begin
          if (mismatch_count < 10)
            $display("[%0t] output beat %0d with nothing expected", $realtime, out_sample_out);
          mismatch_count++;
        end else begin
          want = expected_mix.pop_front();
          checked_count++;
          if (out_sample_out !== want) begin
            if (mismatch_count < 10)
              $display("[%0t] sample_out mismatch: expected %0d, got %0d",
                       $realtime, want, out_sample_out);
            mismatch_count++;
          end
        end
      end
    end
    pending_count = expected_mix.size();
  end

endmodule

>>> verif/feedback_delay_echo_tb.sv
// Testbench top for the feedback delay echo: stimulus, config phases, watchdog and verdict.
module feedback_delay_echo_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SB    = 24;
  localparam int DEPTH = 65536;
  // The clearing pass after reset alone moves no beat while it zeroes the
  // whole store, so the quiet-cycle limit is a multiple of the store depth.
  localparam int WATCHDOG_LIMIT = 4 * DEPTH;
  localparam int PHASE_BEATS    = 250;
  // Mode code the block leaves unused: it must do nothing and return zero.
  localparam logic [fde_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  logic signed [SB-1:0]           in_sample_in;
  logic [fde_pkg::MODE_W-1:0]     in_mode;
  logic                           out_valid;
  logic                           out_ready;
  logic signed [SB-1:0]           out_sample_out;
  logic                           cfg_we;
  logic [fde_pkg::CFG_IDX_W-1:0]  cfg_addr;
  logic [fde_pkg::CFG_W-1:0]      cfg_wdata;

  int mismatches;
  int pending;
  int checked;
  int beats_sent;
  int settings_used;
  int quiet_cycles;
  bit steady;   // when set, neither side idles

  feedback_delay_echo #(
    .STORE_DEPTH(DEPTH),
    .SAMPLE_BITS(SB)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_in   (in_sample_in),
    .in_mode        (in_mode),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata)
  );

  feedback_delay_echo_checker #(
    .STORE_DEPTH(DEPTH),
    .SAMPLE_BITS(SB)
  ) u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_in   (in_sample_in),
    .in_mode        (in_mode),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatches),
    .pending_count  (pending),
    .checked_count  (checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Output side backpressure: drop ready in about a quarter of the cycles,
  // except during steady stretches.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= steady || ($urandom_range(0, 99) >= 24);
    end
  end

  // Watchdog: any cycle with no beat on either channel counts toward the limit.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no beat moved for %0d cycles, %0d results outstanding",
               quiet_cycles, pending);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Sample mix: full-scale extremes, values near zero, and raw random words
  // so that every bit of the field toggles.
  function automatic logic signed [SB-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return S_MAX;
      1: return S_MIN;
      2, 3: return SB'(int'($urandom_range(0, 64)) - 32);
      default: return SB'($urandom());
    endcase
  endfunction

  function automatic logic [fde_pkg::MODE_W-1:0] pick_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return fde_pkg::MODE_PROC_ADV;
    if (r < 85) return fde_pkg::MODE_PROC;
    if (r < 95) return fde_pkg::MODE_ADV;
    return MODE_UNUSED;
  endfunction

  // Delay: mostly short so echoes come back within the phase; zero and the
  // longest distance show up now and then.
  function automatic logic [fde_pkg::CFG_W-1:0] pick_delay();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return '0;
      1: return '1;
      2: return fde_pkg::CFG_W'($urandom());
      default: return fde_pkg::CFG_W'($urandom_range(1, 24));
    endcase
  endfunction

  function automatic logic [fde_pkg::CFG_W-1:0] pick_feedback();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return '0;
      1: return fde_pkg::FEEDBACK_LIMIT;
      2: return fde_pkg::FEEDBACK_LIMIT + 1'b1;
      3: return '1;
      default: return fde_pkg::CFG_W'($urandom_range(0, fde_pkg::FEEDBACK_LIMIT));
    endcase
  endfunction

  function automatic logic [fde_pkg::CFG_W-1:0] pick_gain();
    int r;
    r = $urandom_range(0, 5);
    case (r)
      0: return '0;
      1: return '1;
      default: return fde_pkg::CFG_W'($urandom());
    endcase
  endfunction

  // One input beat. Called at a falling edge; returns at the falling edge
  // after the beat was taken. Valid is held with a stable payload until then.
  task automatic send_beat(input logic signed [SB-1:0] s,
                           input logic [fde_pkg::MODE_W-1:0] m);
    while (!steady && $urandom_range(0, 99) < 24) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= s;
    in_mode      <= m;
    do begin
      @(posedge clk);
    end while (!in_ready);
    @(negedge clk);
    beats_sent++;
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do begin
      @(negedge clk);
    end while (pending != 0);
  endtask

  // Write all four registers on consecutive cycles; only called when idle.
  task automatic program_regs(input logic [fde_pkg::CFG_W-1:0] dl,
                              input logic [fde_pkg::CFG_W-1:0] fb,
                              input logic [fde_pkg::CFG_W-1:0] wg,
                              input logic [fde_pkg::CFG_W-1:0] dg);
    logic [fde_pkg::CFG_W-1:0]     vals [4];
    logic [fde_pkg::CFG_IDX_W-1:0] idxs [4];
    vals = '{dl, fb, wg, dg};
    idxs = '{fde_pkg::REG_DELAY_LENGTH, fde_pkg::REG_FEEDBACK_GAIN,
             fde_pkg::REG_WET_GAIN, fde_pkg::REG_DRY_GAIN};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= idxs[i];
      cfg_wdata <= vals[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_sample_in = '0;
    in_mode      = fde_pkg::MODE_PROC_ADV;
    cfg_we       = 1'b0;
    cfg_addr     = fde_pkg::REG_DELAY_LENGTH;
    cfg_wdata    = '0;
    steady       = 1'b0;
    beats_sent   = 0;
    settings_used = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // --- directed part ---
    // Reset settings: one-sample delay, no feedback, full wet and dry.
    // The first beat also waits out the store clearing pass.
    send_beat(S_MAX, fde_pkg::MODE_PROC_ADV);
    send_beat(S_MIN, fde_pkg::MODE_PROC_ADV);
    send_beat('0, fde_pkg::MODE_PROC_ADV);
    send_beat('1, fde_pkg::MODE_PROC_ADV);
    send_beat(S_MAX, fde_pkg::MODE_PROC);     // process in place, no advance
    send_beat(S_MIN, fde_pkg::MODE_ADV);      // advance only, output zero
    send_beat(S_MAX, MODE_UNUSED);            // unused mode: no effect, output zero
    send_beat(24'h555555, fde_pkg::MODE_PROC_ADV);
    send_beat(24'hAAAAAA, fde_pkg::MODE_PROC_ADV);
    drain();

    // Zero delay reads back the sample written by the same beat; feedback at
    // its top legal code drives the stored value into saturation.
    program_regs('0, fde_pkg::FEEDBACK_LIMIT, '1, '0);
    send_beat(S_MAX, fde_pkg::MODE_PROC_ADV);
    send_beat(S_MAX, fde_pkg::MODE_PROC_ADV);
    send_beat(S_MAX, fde_pkg::MODE_PROC);
    send_beat(S_MIN, fde_pkg::MODE_PROC_ADV);
    send_beat(S_MIN, fde_pkg::MODE_PROC_ADV);
    drain();

    // Feedback one code above the limit must act as zero; wet muted.
    program_regs(16'd2, fde_pkg::FEEDBACK_LIMIT + 1'b1, '0, '1);
    send_beat(S_MAX, fde_pkg::MODE_PROC_ADV);
    send_beat(S_MIN, fde_pkg::MODE_PROC_ADV);
    send_beat(S_MAX, fde_pkg::MODE_PROC_ADV);
    send_beat(24'h000001, fde_pkg::MODE_PROC_ADV);
    drain();

    // Longest distance: reads the entry just ahead of the write position.
    program_regs('1, '1, 16'h8000, 16'h8000);
    send_beat(S_MAX, fde_pkg::MODE_PROC_ADV);
    send_beat(S_MIN, fde_pkg::MODE_PROC);
    send_beat(S_MIN, fde_pkg::MODE_PROC_ADV);
    send_beat(24'h7FFF00, fde_pkg::MODE_PROC_ADV);
    drain();

    // --- random phases, each under a fresh register setting ---
    for (int ph = 0; ph < 8; ph++) begin
      program_regs(pick_delay(), pick_feedback(), pick_gain(), pick_gain());
      steady = (ph == 3);   // one full phase with no idling on either side
      for (int n = 0; n < PHASE_BEATS; n++) send_beat(pick_sample(), pick_mode());
      steady = 1'b0;
      drain();
    end

    drain();
    repeat (16) @(negedge clk);

    $display("Summary: %0d sample beats sent, %0d output beats checked, %0d register settings",
             beats_sent, checked, settings_used);
    $display("Summary: covered zero and longest delay, feedback at and past its limit, all modes,");
    $display("         random stalls on both sides and one stretch of back-to-back beats");
    if (mismatches == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/fde_pkg.sv
sv/feedback_delay_echo.sv
verif/feedback_delay_echo_checker.sv
verif/feedback_delay_echo_tb.sv
